>>> rtl/quoted_string_unescaper_assert.svh
// Assertion macros for the quoted string unescaper.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef QUOTED_STRING_UNESCAPER_ASSERT_SVH
`define QUOTED_STRING_UNESCAPER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define QSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qsu assertion failed");
// Next-cycle implication.
`define QSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qsu assertion failed");
`else
`define QSU_ASSERT_NOW(label, clk, rst, ante, cons)
`define QSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/qsu_pkg.sv
// Shared types and constants for the quoted string unescaper.
// No dependencies; imported by every RTL module of the block.
package qsu_pkg;

   localparam int CODE_W = 16;
   localparam int VAL_W  = 9;
   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_STR  = 2'd1,
      PH_ESC  = 2'd2
   } phase_type;

   localparam logic [CODE_W-1:0] CH_QUOTE  = 16'h0022;
   localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C;
   localparam logic [CODE_W-1:0] CH_0      = 16'h0030;
   localparam logic [CODE_W-1:0] CH_7      = 16'h0037;
   localparam logic [CODE_W-1:0] CH_9      = 16'h0039;
   localparam logic [CODE_W-1:0] CH_UA     = 16'h0041;
   localparam logic [CODE_W-1:0] CH_UF     = 16'h0046;
   localparam logic [CODE_W-1:0] CH_LA     = 16'h0061;
   localparam logic [CODE_W-1:0] CH_LF     = 16'h0066;

   localparam logic [2:0] HEX_LIMIT = 3'd2;
   localparam logic [2:0] OCT_LIMIT = 3'd3;

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              line_end;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] out_code;
      logic              has_char;
      logic              string_end;
      logic              string_found;
   } rsp_type;

   // Up to three results raised by one request, plus how many are live.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] item;
      logic [1:0]                count;
   } bundle_type;

endpackage

>>> rtl/qsu_decoder.sv
// Per-character parser and escape decoder with its state registers.
// Depends on qsu_pkg.
module qsu_decoder
   import qsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       octal_mode,
   input  req_type    req,
   output bundle_type bundle
);

   phase_type         phase_ff, phase_in, phase_mid;
   logic [1:0]        cnt_ff, cnt_in, cnt_mid;
   logic [VAL_W-1:0]  val_ff, val_in, val_mid;

   logic              is_dig;
   logic [3:0]        dval;
   logic [12:0]       esc_sum;
   logic [2:0]        cnt_next;
   logic [2:0]        limit;
   logic              in_esc;
   logic              esc_break;
   logic              esc_full;
   logic              do_str;
   logic              is_quote;
   logic              is_bslash;

   function automatic rsp_type mk_char(input logic [CODE_W-1:0] code);
      rsp_type r;
      r.out_code     = code;
      r.has_char     = 1'b1;
      r.string_end   = 1'b0;
      r.string_found = 1'b0;
      return r;
   endfunction

   function automatic rsp_type mk_end(input logic found);
      rsp_type r;
      r.out_code     = '0;
      r.has_char     = 1'b0;
      r.string_end   = 1'b1;
      r.string_found = found;
      return r;
   endfunction

   // digit classification under the mode in force
   always_comb begin
      is_dig = 1'b0;
      dval   = '0;
      if (req.char_code inside {[CH_0:CH_7]}) begin
         is_dig = 1'b1;
         dval   = 4'(req.char_code - CH_0);
      end else if (!octal_mode) begin
         if (req.char_code inside {[CH_0:CH_9]}) begin
            is_dig = 1'b1;
            dval   = 4'(req.char_code - CH_0);
         end else if (req.char_code inside {[CH_UA:CH_UF]}) begin
            is_dig = 1'b1;
            dval   = 4'(req.char_code - CH_UA + 16'd10);
         end else if (req.char_code inside {[CH_LA:CH_LF]}) begin
            is_dig = 1'b1;
            dval   = 4'(req.char_code - CH_LA + 16'd10);
         end
      end
   end

   assign is_quote  = (req.char_code == CH_QUOTE);
   assign is_bslash = (req.char_code == CH_BSLASH);
   assign esc_sum   = (octal_mode ? {1'b0, val_ff, 3'b000} : {val_ff, 4'b0000})
                      + 13'(dval);
   assign cnt_next  = {1'b0, cnt_ff} + 3'd1;
   assign limit     = octal_mode ? OCT_LIMIT : HEX_LIMIT;
   assign in_esc    = (phase_ff == PH_ESC);
   assign esc_break = in_esc && !is_dig;
   assign esc_full  = in_esc && is_dig && (cnt_ff != 2'd0) && (cnt_next >= limit);
   assign do_str    = (phase_ff == PH_STR) || esc_break;

   // next state
   always_comb begin
      phase_mid = phase_ff;
      cnt_mid   = cnt_ff;
      val_mid   = val_ff;
      case (phase_ff)
         PH_STR: begin
         end
         PH_ESC: begin
            if (!is_dig) begin
               phase_mid = PH_STR;
            end else if (cnt_ff == 2'd0) begin
               val_mid = VAL_W'(dval);
               cnt_mid = 2'd1;
            end else if (esc_full) begin
               phase_mid = PH_STR;
               cnt_mid   = 2'd0;
            end else begin
               val_mid = esc_sum[VAL_W-1:0];
               cnt_mid = cnt_next[1:0];
            end
         end
         default: begin
            phase_mid = is_quote ? PH_STR : PH_SEEK;
         end
      endcase
      if (do_str) begin
         if (is_quote) begin
            phase_mid = PH_SEEK;
         end else if (is_bslash) begin
            phase_mid = PH_ESC;
            cnt_mid   = 2'd0;
            val_mid   = '0;
         end
      end
      if (req.line_end) begin
         phase_in = PH_SEEK;
         cnt_in   = 2'd0;
         val_in   = '0;
      end else begin
         phase_in = phase_mid;
         cnt_in   = cnt_mid;
         val_in   = val_mid;
      end
   end

   // results
   always_comb begin
      logic [1:0] n;
      n = 2'd0;
      bundle = '0;
      if (esc_break) begin
         bundle.item[n] = mk_char((cnt_ff == 2'd0) ? CH_BSLASH : CODE_W'(val_ff));
         n = n + 2'd1;
      end
      if (esc_full) begin
         bundle.item[n] = mk_char(CODE_W'(esc_sum));
         n = n + 2'd1;
      end
      if (do_str) begin
         if (is_quote) begin
            bundle.item[n] = mk_end(1'b1);
            n = n + 2'd1;
         end else if (!is_bslash) begin
            bundle.item[n] = mk_char(req.char_code);
            n = n + 2'd1;
         end
      end
      if (req.line_end) begin
         if (phase_mid == PH_ESC && cnt_mid != 2'd0) begin
            bundle.item[n] = mk_char(CODE_W'(val_mid));
            n = n + 2'd1;
         end
         bundle.item[n] = mk_end(phase_mid == PH_STR || phase_mid == PH_ESC);
         n = n + 2'd1;
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         cnt_ff   <= 2'd0;
         val_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         val_ff   <= val_in;
      end
   end

endmodule

>>> rtl/qsu_result_buf.sv
// Result register: holds the results of one request and drains one a cycle while rsp_ready is high.
// Depends on qsu_pkg and quoted_string_unescaper_assert.svh.
`include "quoted_string_unescaper_assert.svh"
module qsu_result_buf
   import qsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type bundle,
   output logic       can_take,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   rsp_type [MAX_RESULTS-1:0] items_ff;
   logic                      valid_ff;
   logic [1:0]                idx_ff;
   logic [1:0]                last_ff;
   logic                      take;
   logic                      drain_last;

   assign take       = valid_ff && rsp_ready;
   assign drain_last = take && (idx_ff == last_ff);
   assign can_take   = !valid_ff || drain_last;
   assign rsp_valid  = valid_ff;
   assign rsp_data   = items_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
         last_ff  <= 2'd0;
      end else if (push) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
         last_ff  <= bundle.count - 2'd1;
      end else if (drain_last) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         items_ff <= bundle.item;
      end
   end

   `QSU_ASSERT_NOW(a_idx_in_range, clock, reset, valid_ff, idx_ff <= last_ff && last_ff != 2'd3)
   `QSU_ASSERT_NOW(a_push_when_free, clock, reset, push, can_take && bundle.count != 2'd0)
   `QSU_ASSERT_NEXT(a_push_loads, clock, reset, push, valid_ff && idx_ff == 2'd0)
   `QSU_ASSERT_NEXT(a_step, clock, reset, take && !drain_last && !push, valid_ff && idx_ff == $past(idx_ff) + 2'd1)

endmodule

>>> rtl/quoted_string_unescaper.sv
// Quoted string unescaper, top level: handshakes, mode register, decoder and result register.
// Depends on qsu_pkg, qsu_decoder and qsu_result_buf.
//
// Takes one 16-bit character per request and pulls the double-quoted strings out of a
// modem response line, decoding backslash escapes (two hex digits, or three octal digits
// when octal mode is set) and closing each string with an end marker result. A request
// is decoded in the cycle it is accepted and its results (none to three) land in a
// three-entry result register that drains one result per cycle while rsp_ready is high.
// Requests that raise at most one result then flow back to back; one that raises more
// holds off the next request until its results drain, the drain of the result register
// being the limit. req_ready stays high while the last held result is taken, so the
// next request enters in that same cycle. There is no start-up or clearing delay.
module quoted_string_unescaper
   import qsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   // mode register, write only
   input  logic    csr_write_en,
   input  logic    csr_write_data
);

   logic       octal_ff;
   logic       octal_in;
   logic       accept;
   logic       can_take;
   bundle_type bundle;

   // mode register: the user must write it only while the block is idle; the block does not enforce this
   assign octal_in = csr_write_en ? csr_write_data : octal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         octal_ff <= 1'b0;
      end else begin
         octal_ff <= octal_in;
      end
   end

   // a request enters whenever the result register is free or emptying this cycle
   assign req_ready = can_take;
   assign accept    = req_valid && req_ready;

   qsu_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .octal_mode (octal_ff),
      .req        (req_data),
      .bundle     (bundle)
   );

   // requests that raise no result leave the result register alone
   qsu_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && bundle.count != 2'd0),
      .bundle    (bundle),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
